@@ src/ddq_pkg.sv @@
// Package for the double-ended queue: sizes, operation and status codes,
// beat structs and the per-cell control struct. No dependencies.
`timescale 1ns / 1ps

package ddq_pkg;

  // Number of storage cells in the chain
  localparam int unsigned DEPTH = 16;
  // Width of the occupancy counter, able to hold DEPTH itself
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Operation codes carried in the kind field
  typedef enum logic [2:0] {
    KIND_ADD_FRONT = 3'd0,
    KIND_ADD_BACK  = 3'd1,
    KIND_REM_FRONT = 3'd2,
    KIND_REM_BACK  = 3'd3,
    KIND_PEEK      = 3'd4
  } kind_e;

  // Status codes carried in the result beat
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Input beat
  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
  } deq_in_t;

  // Result beat
  typedef struct packed {
    logic signed [31:0] taken_value;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [4:0]         fill_count;
    logic               is_empty;
    logic               is_full;
    logic [1:0]         status;
  } deq_out_t;

  // Shift / load command broadcast to every cell
  typedef struct packed {
    logic shift_right;  // add at front: every value moves one cell back
    logic shift_left;   // remove at front: every value moves one cell forward
    logic load_back;    // add at back: the selected cell takes the new value
  } cell_ctrl_t;

endpackage

@@ src/ddq_cell.sv @@
// One storage cell of the queue chain. Takes its neighbor's value on a
// shift, or the new value on a back load. Depends on ddq_pkg.
`timescale 1ns / 1ps

module ddq_cell import ddq_pkg::*; (
  input  logic               clk_i,
  input  cell_ctrl_t         ctrl_i,
  input  logic               sel_i,    // this cell is the first free slot
  input  logic signed [31:0] value_i,  // value of an add at back
  input  logic signed [31:0] left_i,   // neighbor toward the front
  input  logic signed [31:0] right_i,  // neighbor toward the back
  output logic signed [31:0] data_o,   // stored value
  output logic signed [31:0] next_o    // value after this edge
);

  logic signed [31:0] data_q, data_d;

  // next value: shift in from a neighbor or load a new value
  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_right) begin
      data_d = left_i;
    end else if (ctrl_i.shift_left) begin
      data_d = right_i;
    end else if (ctrl_i.load_back && sel_i) begin
      data_d = value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign next_o = data_d;

endmodule

@@ src/double_ended_queue.sv @@
// Top level of the double-ended queue: a chain of ddq_cell storage cells,
// the occupancy counter and the registered result beat. Depends on ddq_pkg.
`timescale 1ns / 1ps
//
// Usage
// - Input channel (in_valid_i / in_ready_o / in_data_i) carries one operation
//   per beat: add at front, add at back, remove at front, remove at back, or
//   peek. Unknown kinds act as peek.
// - Output channel (out_valid_o / out_ready_i / out_data_o) returns exactly
//   one result beat per input beat, in order.
// - Values sit packed from cell 0 (front) toward the back. Adds and removes
//   at the front shift the whole chain by one cell; an add at the back loads
//   only the cell at the fill boundary and a remove at the back only lowers the count.
// - The result is registered and shows in the cycle after the input beat
//   is taken. Throughput: one operation per cycle while the receiver does
//   not stall, set by the single shift step of the cell chain.
// - If the receiver stalls, the result register holds its beat and
//   in_ready_o follows out_ready_i, so no further operation is taken until
//   the waiting result leaves.
// - Reset empties the queue (count zero) and drops any pending result; the
//   cell contents are not cleared and are never shown while unoccupied.
//
module double_ended_queue import ddq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  deq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output deq_out_t out_data_o
);

  logic               accept;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q;
  deq_out_t           out_q, out_d;
  cell_ctrl_t         ctrl;
  logic [DEPTH-1:0]   sel_vec;
  logic [DEPTH-1:0]   tail_cur;
  logic [DEPTH-1:0]   tail_next;
  logic signed [31:0] cell_q [DEPTH];
  logic signed [31:0] cell_d [DEPTH];
  logic signed [31:0] back_cur;
  logic signed [31:0] back_next;
  logic               full;
  logic               empty;
  logic [1:0]         status;
  logic signed [31:0] taken;
  logic [31:0]        cnt_wide;

  // handshake: take a beat whenever the result slot is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign full  = (cnt_q == CNT_W'(DEPTH));
  assign empty = (cnt_q == '0);

  // per-cell position flags: first free slot, current and next last value
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      sel_vec[i]   = (cnt_q == CNT_W'(i));
      tail_cur[i]  = (cnt_q == CNT_W'(i + 1));
      tail_next[i] = (cnt_d == CNT_W'(i + 1));
    end
  end

  // one-hot select of the back value before and after the step
  always_comb begin
    back_cur  = '0;
    back_next = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_cur  = back_cur  | (cell_q[i] & {32{tail_cur[i]}});
      back_next = back_next | (cell_d[i] & {32{tail_next[i]}});
    end
  end

  // operation decode
  always_comb begin
    ctrl   = '0;
    cnt_d  = cnt_q;
    status = ST_OK;
    taken  = '0;
    if (accept) begin
      case (in_data_i.kind)
        KIND_ADD_FRONT: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            ctrl.shift_right = 1'b1;
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
        KIND_ADD_BACK: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            ctrl.load_back = 1'b1;
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
        KIND_REM_FRONT: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            ctrl.shift_left = 1'b1;
            taken = cell_q[0];
            cnt_d = cnt_q - CNT_W'(1);
          end
        end
        KIND_REM_BACK: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            taken = back_cur;
            cnt_d = cnt_q - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // cell chain: cell 0 is the front
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [31:0] left, right;
    if (g == 0) begin : g_first
      assign left = in_data_i.value;
    end else begin : g_mid_l
      assign left = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_q[g+1];
    end
    ddq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .sel_i   (sel_vec[g]),
      .value_i (in_data_i.value),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_q[g]),
      .next_o  (cell_d[g])
    );
  end

  // result beat assembled from the state after the step
  assign cnt_wide = 32'(cnt_d);
  always_comb begin
    out_d.taken_value = taken;
    out_d.front_value = (cnt_d != '0) ? cell_d[0] : '0;
    out_d.back_value  = back_next;
    out_d.fill_count  = cnt_wide[4:0];
    out_d.is_empty    = (cnt_d == '0);
    out_d.is_full     = (cnt_d == CNT_W'(DEPTH));
    out_d.status      = status;
  end

  // occupancy counter and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sim/double_ended_queue_test.sv @@
// Self-checking testbench for double_ended_queue: directed and random operation
// beats under varied sender idling and receiver stalls. Depends on ddq_pkg.
`timescale 1ns / 1ps

module double_ended_queue_test;
  import ddq_pkg::*;

  // Tracks deque contents and holds the result beats still owed by the block
  class deque_scoreboard;
    logic [31:0] cells [DEPTH];
    int unsigned head = 0;   // slot of the front value
    int unsigned tail = 0;   // next slot an add at back fills
    int unsigned count = 0;
    deq_out_t    owed [$];
    int          errors = 0;

    // Predict the result beat for an accepted operation beat
    function void note_op(deq_in_t op);
      deq_out_t res;
      res = '0;
      res.status = ST_OK;
      case (op.kind)
        KIND_ADD_FRONT, KIND_ADD_BACK: begin
          if (count >= DEPTH) begin
            res.status = ST_FULL;
          end else if (op.kind == KIND_ADD_FRONT) begin
            head = (head + DEPTH - 1) % DEPTH;
            cells[head] = op.value;
            count++;
          end else begin
            cells[tail] = op.value;
            tail = (tail + 1) % DEPTH;
            count++;
          end
        end
        KIND_REM_FRONT, KIND_REM_BACK: begin
          if (count == 0) begin
            res.status = ST_EMPTY;
          end else if (op.kind == KIND_REM_FRONT) begin
            res.taken_value = cells[head];
            head = (head + 1) % DEPTH;
            count--;
          end else begin
            tail = (tail + DEPTH - 1) % DEPTH;
            res.taken_value = cells[tail];
            count--;
          end
        end
        default: ;  // peek and unknown kinds leave the state alone
      endcase
      if (count != 0) begin
        res.front_value = cells[head];
        res.back_value  = cells[(tail + DEPTH - 1) % DEPTH];
      end
      res.fill_count = 5'(count);
      res.is_empty   = (count == 0);
      res.is_full    = (count >= DEPTH);
      owed.push_back(res);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare an accepted result beat with the oldest prediction
    function void check_result(deq_out_t got);
      deq_out_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = owed.pop_front();
      check_field("taken_value", want.taken_value, got.taken_value);
      check_field("front_value", want.front_value, got.front_value);
      check_field("back_value",  want.back_value,  got.back_value);
      check_field("fill_count",  32'(want.fill_count), 32'(got.fill_count));
      check_field("is_empty",    32'(want.is_empty),   32'(got.is_empty));
      check_field("is_full",     32'(want.is_full),    32'(got.is_full));
      check_field("status",      32'(want.status),     32'(got.status));
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  deq_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  deq_out_t out_data_o;

  deque_scoreboard sb;
  int idle_pct = 0;    // sender idle chance per cycle, percent
  int stall_pct = 0;   // receiver stall chance per cycle, percent

  double_ended_queue dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: random backpressure, changed on the falling edge
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // Drive one operation beat after a random idle gap, return once accepted
  task automatic send_op(input logic [2:0] kind, input logic [31:0] value);
    int gap;
    gap = 0;
    while (gap < 50 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{kind: kind, value: value};
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_op(in_data_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Random beats in stretches that lean toward filling, draining or neither,
  // so full and empty are both hit often
  task automatic run_phase(input int idle, input int stall, input int n);
    int add_pct;
    int left;
    int r;
    logic [2:0] kind;
    idle_pct  = idle;
    stall_pct = stall;
    left = 0;
    add_pct = 50;
    repeat (n) begin
      if (left == 0) begin
        left = $urandom_range(48, 16);
        case ($urandom_range(2))
          0:       add_pct = 85;
          1:       add_pct = 50;
          default: add_pct = 15;
        endcase
      end
      left--;
      r = $urandom_range(99);
      if (r < 3) kind = 3'($urandom_range(7, 5));
      else if (r < 8) kind = KIND_PEEK;
      else if ($urandom_range(99) < add_pct)
        kind = $urandom_range(1) ? KIND_ADD_FRONT : KIND_ADD_BACK;
      else
        kind = $urandom_range(1) ? KIND_REM_FRONT : KIND_REM_BACK;
      send_op(kind, pick_value());
    end
  endtask

  initial begin
    int settle;
    sb = new;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty-store cases, unknown kinds, extreme values at both ends
    send_op(KIND_PEEK, 32'h1234_5678);
    send_op(KIND_REM_FRONT, 32'h0);
    send_op(KIND_REM_BACK, 32'hFFFF_FFFF);
    send_op(3'd5, 32'h0);
    send_op(3'd6, 32'h0);
    send_op(3'd7, 32'hFFFF_FFFF);
    send_op(KIND_ADD_FRONT, 32'h8000_0000);
    send_op(KIND_ADD_BACK, 32'h7FFF_FFFF);
    send_op(KIND_ADD_BACK, 32'h0000_0000);
    send_op(KIND_ADD_FRONT, 32'hFFFF_FFFF);
    send_op(KIND_PEEK, 32'h0);
    send_op(KIND_REM_FRONT, 32'h0);
    send_op(KIND_REM_BACK, 32'h0);
    send_op(KIND_REM_FRONT, 32'h0);
    send_op(KIND_REM_BACK, 32'h0);
    send_op(KIND_REM_FRONT, 32'h0);
    send_op(KIND_ADD_BACK, 32'hA5A5_5A5A);
    send_op(KIND_REM_FRONT, 32'h0);

    // Random phases with different idling
    run_phase(0, 0, 290);
    run_phase(78, 0, 290);
    run_phase(0, 78, 290);
    run_phase(8, 8, 290);
    in_valid_i <= 1'b0;

    // Drain, then keep watching the block for stray beats
    while (sb.owed.size() != 0) @(posedge clk_i);
    settle = 0;
    while (settle < 20) begin
      @(posedge clk_i);
      settle++;
    end
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
